>>> rtl/qes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_pkg
// Shared widths, reset values, unit opcodes and interface types for the
// four-lane seeded moving average block.
// ----------------------------------------------------------------------------
package qes_pkg;

    // Lane count and bar limit
    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int MAX_PERIOD = 1023;

    // Field widths
    localparam int PRICE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int PERIOD_W   = 10;
    localparam int ALPHA_W    = 17;
    localparam int CNT_W      = 10;
    localparam int SUM_W      = 42;
    localparam int DIVD_W     = SUM_W + 1;
    localparam int DIV_STEP_W = $clog2(DIVD_W);
    localparam int PROD_W     = PRICE_W + ALPHA_W;
    localparam int CFG_IDX_W  = $clog2(2 * LANES);
    localparam int CFG_DATA_W = ALPHA_W;

    typedef logic [PRICE_W-1:0]  price_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [ALPHA_W-1:0]  alpha_t;

    // Q1.16 unity weight and rounding half
    localparam alpha_t ALPHA_ONE = alpha_t'(65536);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // Register reset values
    localparam period_t PERIOD_RST [LANES] = '{10'd5, 10'd20, 10'd60, 10'd200};
    localparam alpha_t  ALPHA_RST  [LANES] = '{17'd21845, 17'd6242, 17'd2149, 17'd652};

    // Shared unit opcodes
    localparam logic OP_EMA = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Request to the shared unit
    typedef struct packed {
        logic               start;
        logic               op;
        price_t             prev;
        price_t             close;
        alpha_t             alpha;
        logic [DIVD_W-1:0]  dividend;
        period_t            divisor;
    } alu_req_t;

    // Response from the shared unit
    typedef struct packed {
        logic   done;
        price_t result;
    } alu_rsp_t;

endpackage

>>> rtl/qes_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_cfg
// Period and weight registers of the four lanes, written through a plain
// indexed write port: periods first, then weights.
// ----------------------------------------------------------------------------
module qes_cfg (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic [qes_pkg::CFG_IDX_W-1:0]               cfg_addr,
    input  logic [qes_pkg::CFG_DATA_W-1:0]              cfg_wdata,
    output qes_pkg::period_t [qes_pkg::LANES-1:0]       period,
    output qes_pkg::alpha_t  [qes_pkg::LANES-1:0]       alpha
);
    import qes_pkg::*;

    period_t [LANES-1:0] period_reg;
    alpha_t  [LANES-1:0] alpha_reg;
    logic [LANE_W-1:0]   lane_sel;
    logic                is_period;

    // Decode the register index into lane and register kind
    assign lane_sel  = cfg_addr[LANE_W-1:0];
    assign is_period = (cfg_addr < CFG_IDX_W'(LANES));

    // Hold the register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                period_reg[i] <= PERIOD_RST[i];
                alpha_reg[i]  <= ALPHA_RST[i];
            end
        end else if (cfg_wr_en) begin
            if (is_period) begin
                period_reg[lane_sel] <= cfg_wdata[PERIOD_W-1:0];
            end else begin
                alpha_reg[lane_sel] <= cfg_wdata[ALPHA_W-1:0];
            end
        end
    end

    assign period = period_reg;
    assign alpha  = alpha_reg;

endmodule

>>> rtl/qes_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_alu
// Shared arithmetic unit. One opcode steps an average toward the close
// (signed weight product, rounded to nearest, ties away from zero); the
// other runs a restoring divide, one quotient bit per cycle, for seeding.
// ----------------------------------------------------------------------------
module qes_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  qes_pkg::alu_req_t req,
    output qes_pkg::alu_rsp_t rsp
);
    import qes_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_ADD  = 2'd2;
    localparam logic [1:0] A_DIV  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  done_reg;
    logic                  neg_reg;
    price_t                mag_reg;
    alpha_t                alpha_reg;
    price_t                prev_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DIVD_W-1:0]     num_reg;
    period_t               rem_reg;
    period_t               div_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    price_t                result_reg;

    logic                  start_neg;
    price_t                start_mag;
    alpha_t                start_alpha;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     trial_diff;
    logic                  qbit;
    logic [DIVD_W-1:0]     num_next;
    logic [PROD_W-1:0]     round_sum;
    price_t                q_mag;
    price_t                ema_result;
    logic                  div_last;

    // Prepare magnitude, sign and saturated weight of the update
    always_comb begin
        start_neg   = (req.close < req.prev);
        start_mag   = start_neg ? (req.prev - req.close) : (req.close - req.prev);
        start_alpha = (req.alpha > ALPHA_ONE) ? ALPHA_ONE : req.alpha;
    end

    // One restoring divide step
    always_comb begin
        trial      = {rem_reg, num_reg[DIVD_W-1]};
        trial_diff = trial - {1'b0, div_reg};
        qbit       = (trial >= {1'b0, div_reg});
        num_next   = {num_reg[DIVD_W-2:0], qbit};
        div_last   = (step_reg == DIV_STEP_W'(DIVD_W - 1));
    end

    // Round the scaled product and apply it with its sign
    always_comb begin
        round_sum  = prod_reg + ROUND_HALF;
        q_mag      = round_sum[FRAC_W+PRICE_W-1:FRAC_W];
        ema_result = neg_reg ? (prev_reg - q_mag) : (prev_reg + q_mag);
    end

    // Sequence the unit
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    state_next = (req.op == OP_DIV) ? A_DIV : A_MUL;
                end
            end
            A_MUL:  state_next = A_ADD;
            A_ADD:  state_next = A_IDLE;
            A_DIV: begin
                if (div_last) begin
                    state_next = A_IDLE;
                end
            end
            default: state_next = A_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == A_ADD) || ((state_reg == A_DIV) && div_last);
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            A_IDLE: begin
                neg_reg   <= start_neg;
                mag_reg   <= start_mag;
                alpha_reg <= start_alpha;
                prev_reg  <= req.prev;
                num_reg   <= req.dividend;
                div_reg   <= req.divisor;
                rem_reg   <= '0;
                step_reg  <= '0;
            end
            A_MUL: begin
                prod_reg <= PROD_W'(mag_reg) * PROD_W'(alpha_reg);
            end
            A_ADD: begin
                result_reg <= ema_result;
            end
            A_DIV: begin
                rem_reg  <= qbit ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
                num_reg  <= num_next;
                step_reg <= step_reg + 1'b1;
                if (div_last) begin
                    result_reg <= num_next[PRICE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

>>> rtl/quad_ema_sma_seeded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_ema_sma_seeded
// Four exponential moving averages over bar closes, each seeded with the
// simple mean of its first N closes.
// ----------------------------------------------------------------------------
// One close comes in per transaction, as a new bar or as a revision of the
// current bar, and one result transaction goes out (a revision before any
// bar is dropped with no result). The lanes are worked one after another on
// a single shared unit: a lane that is not yet due is skipped, an update
// multiplies, rounds and adds, and a seeding bar runs a 43-step restoring
// divide of the running sum by the period. The input is not ready while an
// item is in work; a finished result waits in an output register, and the
// next item is taken while it waits. A lane's average field is zero until
// the lane is valid. Registers 0..3 hold the periods and 4..7 the Q1.16
// weights of the lanes; write them only while the block is idle.
// ----------------------------------------------------------------------------
module quad_ema_sma_seeded (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [qes_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [qes_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Close input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [31:0]                        s_close_price,
    input  logic                               s_is_new_bar,
    // Average output channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [31:0]                        m_avg_fast,
    output logic [31:0]                        m_avg_mid,
    output logic [31:0]                        m_avg_slow,
    output logic [31:0]                        m_avg_long,
    output logic [3:0]                         m_lane_valid
);
    import qes_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_LANE = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    period_t [LANES-1:0]  period;
    alpha_t  [LANES-1:0]  alpha;
    alu_req_t             req;
    alu_rsp_t             rsp;

    logic [2:0]           state_reg, state_next;
    logic [LANE_W-1:0]    lane_reg;
    logic [CNT_W-1:0]     bar_count_reg;
    logic                 beyond_reg;
    logic                 new_reg;
    logic                 add_en_reg;
    logic [SUM_W-1:0]     seed_sum_reg;
    price_t               close_reg;
    price_t               cur_close_reg;
    price_t               ema_before_reg [LANES];
    price_t               ema_cur_reg    [LANES];
    logic                 m_valid_reg;
    price_t [LANES-1:0]   out_avg_reg;
    logic [LANES-1:0]     out_lane_valid_reg;

    logic                 accept;
    logic                 drop;
    logic                 at_limit;
    logic                 last_lane;
    logic                 out_load;
    logic [LANES-1:0]     lane_ok;
    period_t              p_sel;
    logic                 do_seed;
    logic                 do_step;

    qes_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .period    (period),
        .alpha     (alpha)
    );

    qes_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // Handshake and lane status
    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        accept    = s_valid && s_ready;
        at_limit  = (bar_count_reg >= CNT_W'(MAX_PERIOD));
        drop      = !s_is_new_bar && (bar_count_reg == '0) && !beyond_reg;
        last_lane = (lane_reg == LANE_W'(LANES - 1));
        out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
        for (int i = 0; i < LANES; i++) begin
            lane_ok[i] = (period[i] != '0) && (beyond_reg || (bar_count_reg >= period[i]));
        end
        p_sel   = period[lane_reg];
        do_seed = lane_ok[lane_reg] && !beyond_reg && (bar_count_reg == p_sel);
        do_step = lane_ok[lane_reg] && !do_seed;
    end

    // Build the request to the shared unit
    always_comb begin
        req.start    = (state_reg == S_LANE) && (do_seed || do_step);
        req.op       = do_seed ? OP_DIV : OP_EMA;
        req.prev     = new_reg ? ema_cur_reg[lane_reg] : ema_before_reg[lane_reg];
        req.close    = close_reg;
        req.alpha    = alpha[lane_reg];
        req.dividend = {1'b0, seed_sum_reg} + DIVD_W'(p_sel >> 1);
        req.divisor  = p_sel;
    end

    // Sequence one item through the lanes
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !drop) begin
                    state_next = S_SUM;
                end
            end
            S_SUM:  state_next = S_LANE;
            S_LANE: begin
                if (do_seed || do_step) begin
                    state_next = S_WAIT;
                end else if (last_lane) begin
                    state_next = S_OUT;
                end
            end
            S_WAIT: begin
                if (rsp.done) begin
                    state_next = last_lane ? S_OUT : S_LANE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lane_reg      <= '0;
            bar_count_reg <= '0;
            beyond_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Count bars, saturate at the limit
            if (accept && s_is_new_bar) begin
                if (at_limit) begin
                    beyond_reg <= 1'b1;
                end else begin
                    bar_count_reg <= bar_count_reg + 1'b1;
                end
            end
            // Advance the lane pointer
            if (state_reg == S_SUM) begin
                lane_reg <= '0;
            end else if (((state_reg == S_LANE) && !(do_seed || do_step)) ||
                         ((state_reg == S_WAIT) && rsp.done)) begin
                lane_reg <= lane_reg + 1'b1;
            end
            // Hold the result until taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Running sum and current close
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_sum_reg  <= '0;
            cur_close_reg <= '0;
        end else if (accept && !drop) begin
            cur_close_reg <= s_close_price;
            // Take the old close out before a revision adds the new one
            if (!s_is_new_bar && !beyond_reg) begin
                seed_sum_reg <= seed_sum_reg - SUM_W'(cur_close_reg);
            end
        end else if ((state_reg == S_SUM) && add_en_reg) begin
            seed_sum_reg <= seed_sum_reg + SUM_W'(close_reg);
        end
    end

    // Lane averages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                ema_before_reg[i] <= '0;
                ema_cur_reg[i]    <= '0;
            end
        end else begin
            if ((state_reg == S_LANE) && new_reg) begin
                if (do_seed) begin
                    ema_before_reg[lane_reg] <= '0;
                end else if (do_step) begin
                    ema_before_reg[lane_reg] <= ema_cur_reg[lane_reg];
                end
            end
            if ((state_reg == S_WAIT) && rsp.done) begin
                ema_cur_reg[lane_reg] <= rsp.result;
            end
        end
    end

    // Item payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            close_reg  <= s_close_price;
            new_reg    <= s_is_new_bar;
            add_en_reg <= s_is_new_bar ? !at_limit : !beyond_reg;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < LANES; i++) begin
                out_avg_reg[i] <= lane_ok[i] ? ema_cur_reg[i] : '0;
            end
            out_lane_valid_reg <= lane_ok;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_avg_fast   = out_avg_reg[0];
    assign m_avg_mid    = out_avg_reg[1];
    assign m_avg_slow   = out_avg_reg[2];
    assign m_avg_long   = out_avg_reg[3];
    assign m_lane_valid = out_lane_valid_reg;

endmodule

>>> rtl/qes_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_chk
// Port-level checks of the seeded moving average block, bound to its top.
// ----------------------------------------------------------------------------
module qes_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_is_new_bar,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [31:0]                         m_avg_fast,
    input logic [31:0]                         m_avg_mid,
    input logic [31:0]                         m_avg_slow,
    input logic [31:0]                         m_avg_long,
    input logic [3:0]                          m_lane_valid
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_avg_fast) && $stable(m_avg_mid) &&
            $stable(m_avg_slow) && $stable(m_avg_long) && $stable(m_lane_valid))
        else $error("result changed while stalled");

    // A new bar always starts work, so the input drops ready
    a_busy_after_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_new_bar |=> !s_ready)
        else $error("input still ready after a new bar");

    // A fresh result comes out as the block returns to idle
    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while busy");

    // Lanes that are not valid report zero
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lane_valid[0] || (m_avg_fast == 32'd0)) &&
            (m_lane_valid[1] || (m_avg_mid == 32'd0)) &&
            (m_lane_valid[2] || (m_avg_slow == 32'd0)) &&
            (m_lane_valid[3] || (m_avg_long == 32'd0)))
        else $error("invalid lane with nonzero average");

endmodule

bind quad_ema_sma_seeded qes_chk u_qes_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_is_new_bar (s_is_new_bar),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_avg_fast   (m_avg_fast),
    .m_avg_mid    (m_avg_mid),
    .m_avg_slow   (m_avg_slow),
    .m_avg_long   (m_avg_long),
    .m_lane_valid (m_lane_valid)
);

>>> tb/sv/tb_quad_ema_sma_seeded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_ema_sma_seeded
// Self-checking bench for the four-lane seeded moving average block. A
// scoreboard class keeps its own copy of the lane state, predicts every
// result transaction from the accepted closes and checks the outputs field
// by field. Stimulus runs a directed opening, random phases with fresh
// register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_quad_ema_sma_seeded;
    import qes_pkg::*;

    localparam int SETTLE_CYCLES  = 200;   // worst item: all four lanes seeding
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT    = 100;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD_FAST,
        REG_PERIOD_MID,
        REG_PERIOD_SLOW,
        REG_PERIOD_LONG,
        REG_ALPHA_FAST,
        REG_ALPHA_MID,
        REG_ALPHA_SLOW,
        REG_ALPHA_LONG
    } cfg_reg_e;

    // One result transaction
    typedef struct packed {
        logic [LANES-1:0]   lanes;
        price_t [LANES-1:0] avg;
    } ema_out_t;

    // ------------------------------------------------------------------------
    // Scoreboard: lane state mirror, prediction and result check
    // ------------------------------------------------------------------------
    class ema_scoreboard;
        period_t          period [LANES];
        alpha_t           alpha [LANES];
        price_t           ema_prior [LANES];
        price_t           ema_now [LANES];
        logic [SUM_W-1:0] close_sum;
        logic [CNT_W-1:0] bars;
        price_t           last_close;
        bit               capped;
        ema_out_t         averages_due [$];
        string            lane_name [LANES];
        int               errors;

        function new();
            for (int i = 0; i < LANES; i++) begin
                period[i]    = PERIOD_RST[i];
                alpha[i]     = ALPHA_RST[i];
                ema_prior[i] = '0;
                ema_now[i]   = '0;
            end
            lane_name  = '{"avg_fast", "avg_mid", "avg_slow", "avg_long"};
            close_sum  = '0;
            bars       = '0;
            last_close = '0;
            capped     = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
            if (idx < REG_ALPHA_FAST)
                period[idx] = data[PERIOD_W-1:0];
            else
                alpha[idx - REG_ALPHA_FAST] = data;
        endfunction

        // prev + alpha * (close - prev), product rounded half away from zero
        function price_t weighted_step(price_t prev, price_t close, alpha_t a);
            longint d;
            longint prod;
            longint q;
            alpha_t ac;
            ac = (a > ALPHA_ONE) ? ALPHA_ONE : a;
            d = longint'(close) - longint'(prev);
            prod = d * longint'(ac);
            if (prod >= 0)
                q = (prod + 32768) >>> FRAC_W;
            else
                q = -((-prod + 32768) >>> FRAC_W);
            return price_t'(longint'(prev) + q);
        endfunction

        // Rounded mean of the first p closes
        function price_t mean_seed(period_t p);
            logic [63:0] num;
            num = 64'(close_sum) + 64'(p >> 1);
            return price_t'(num / 64'(p));
        endfunction

        function bit seeds_now(period_t p);
            return p != '0 && !capped && bars == p;
        endfunction

        function bit updates_now(period_t p);
            return p != '0 && (capped || bars > p);
        endfunction

        // Advance the mirror on an accepted close and queue its result
        function void note_input(price_t close, logic is_new);
            ema_out_t res;
            if (is_new) begin
                if (bars >= CNT_W'(MAX_PERIOD)) begin
                    capped = 1'b1;
                end else begin
                    bars = bars + 1'b1;
                    close_sum = close_sum + SUM_W'(close);
                end
                last_close = close;
                for (int i = 0; i < LANES; i++) begin
                    if (seeds_now(period[i])) begin
                        ema_prior[i] = '0;
                        ema_now[i]   = mean_seed(period[i]);
                    end else if (updates_now(period[i])) begin
                        ema_prior[i] = ema_now[i];
                        ema_now[i]   = weighted_step(ema_now[i], close, alpha[i]);
                    end
                end
            end else begin
                // drop a revision that has no bar to revise
                if (bars == '0 && !capped)
                    return;
                if (!capped)
                    close_sum = close_sum - SUM_W'(last_close) + SUM_W'(close);
                last_close = close;
                for (int i = 0; i < LANES; i++) begin
                    if (seeds_now(period[i]))
                        ema_now[i] = mean_seed(period[i]);
                    else if (updates_now(period[i]))
                        ema_now[i] = weighted_step(ema_prior[i], close, alpha[i]);
                end
            end
            res = '0;
            for (int i = 0; i < LANES; i++) begin
                if (seeds_now(period[i]) || updates_now(period[i])) begin
                    res.avg[i]   = ema_now[i];
                    res.lanes[i] = 1'b1;
                end
            end
            averages_due.insert(averages_due.size(), res);
        endfunction

        task report(string what, logic [63:0] want_v, logic [63:0] got_v);
            if (errors < PRINT_LIMIT)
                $display("%0t ns mismatch: %s expected %h got %h", $time, what, want_v, got_v);
            errors++;
        endtask

        task check_result(ema_out_t got);
            ema_out_t want;
            if (averages_due.size() == 0) begin
                report("result with no close pending", 0, got.lanes);
                return;
            end
            want = averages_due.pop_front();
            if (got.lanes !== want.lanes)
                report("lane_valid", want.lanes, got.lanes);
            for (int i = 0; i < LANES; i++) begin
                if (got.avg[i] !== want.avg[i])
                    report(lane_name[i], want.avg[i], got.avg[i]);
            end
        endtask

        task finish_check();
            if (averages_due.size() != 0)
                report("results still pending", averages_due.size(), 0);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    price_t                s_close_price = '0;
    logic                  s_is_new_bar = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    price_t                m_avg_fast;
    price_t                m_avg_mid;
    price_t                m_avg_slow;
    price_t                m_avg_long;
    logic [LANES-1:0]      m_lane_valid;

    ema_scoreboard sb;
    period_t       cfg_period [LANES];
    alpha_t        cfg_alpha [LANES];
    price_t        last_close = '0;
    int            sent_bars = 0;
    int            idle_cycles = 0;
    bit            tx_gaps = 1'b1;
    bit            rx_gaps = 1'b1;
    bit            hold_req = 1'b0;

    quad_ema_sma_seeded dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_close_price(s_close_price),
        .s_is_new_bar (s_is_new_bar),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_avg_fast   (m_avg_fast),
        .m_avg_mid    (m_avg_mid),
        .m_avg_slow   (m_avg_slow),
        .m_avg_long   (m_avg_long),
        .m_lane_valid (m_lane_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!tx_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic price_t pick_close();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return price_t'($urandom);
            default: return last_close + price_t'($urandom_range(0, 1 << 20))
                            - price_t'(1 << 19);
        endcase
    endfunction

    // Mix of disabled, extreme, already passed and soon to seed periods
    function automatic period_t pick_period();
        int r;
        int target;
        int now;
        r = $urandom_range(0, 9);
        now = (sent_bars > MAX_PERIOD) ? MAX_PERIOD : sent_bars;
        case (r)
            0: target = 0;
            1: target = 1;
            2: target = MAX_PERIOD;
            3: target = $urandom_range(1, MAX_PERIOD);
            4, 5: target = (now > 1) ? $urandom_range(1, now - 1) : 1;
            default: target = now + $urandom_range(1, 24);
        endcase
        if (target > MAX_PERIOD)
            target = MAX_PERIOD;
        return period_t'(target);
    endfunction

    function automatic alpha_t pick_alpha();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALPHA_ONE;
            2: return '1;
            3: return alpha_t'($urandom_range(65537, 131071));
            4: return alpha_t'(1);
            default: return alpha_t'($urandom_range(1, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offer one close and hold it until the transaction completes
    task automatic send_bar(input price_t close, input logic is_new);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_close_price <= close;
        s_is_new_bar  <= is_new;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (is_new)
            sent_bars++;
        last_close = close;
    endtask

    // Stop offering, wait out any item in work and every result
    task automatic settle();
        s_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (sb.averages_due.size() != 0) @(posedge aclk);
    endtask

    // Write all eight registers from cfg_period and cfg_alpha
    task automatic program_regs();
        logic [CFG_DATA_W-1:0] data;
        cfg_reg_e idx;
        for (int r = REG_PERIOD_FAST; r <= REG_ALPHA_LONG; r++) begin
            idx = cfg_reg_e'(r);
            if (r < REG_ALPHA_FAST)
                data = {7'($urandom), cfg_period[r]};
            else
                data = cfg_alpha[r - REG_ALPHA_FAST];
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= data;
            @(posedge aclk);
            sb.set_reg(idx, data);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n, input bit hold);
        settle();
        for (int i = 0; i < LANES; i++) begin
            cfg_period[i] = pick_period();
            cfg_alpha[i]  = pick_alpha();
        end
        program_regs();
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
        if (hold)
            hold_req = 1'b1;
        repeat (n) send_bar(pick_close(), $urandom_range(0, 99) < 75);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_gaps && $urandom_range(0, 99) < 25) begin
                    r = $urandom_range(0, 99);
                    stall_left = (r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 80);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results before noting the close taken at the same edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ema_out_t got;
        if (aresetn) begin
            got.lanes  = m_lane_valid;
            got.avg[0] = m_avg_fast;
            got.avg[1] = m_avg_mid;
            got.avg[2] = m_avg_slow;
            got.avg[3] = m_avg_long;
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_valid && m_ready)
                sb.check_result(got);
            if (s_valid && s_ready)
                sb.note_input(s_close_price, s_is_new_bar);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_quad_ema_sma_seeded: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset periods: revision with no bar yet, extreme closes, fast seed
        send_bar(32'h1234_5678, 1'b0);
        send_bar(32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_0000, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b0);
        send_bar(32'h0001_0000, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_0000, 1'b1);
        send_bar(32'h0000_0000, 1'b0);
        send_bar(32'h8000_0000, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b0);

        // Period moved below the count with no seed, disabled lane, weights
        // of zero, unity and above unity, long lane seeding on bar eight
        settle();
        cfg_period = '{10'd1, 10'd2, 10'd0, 10'd8};
        cfg_alpha  = '{17'd0, 17'h1FFFF, ALPHA_ONE, 17'd32768};
        program_regs();
        send_bar(32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_0000, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b0);
        send_bar(32'h0000_0001, 1'b1);
        send_bar(32'h0000_0000, 1'b0);
        send_bar(32'hFFFF_0000, 1'b1);

        // Largest period, seed of the slow lane on bar twelve
        settle();
        cfg_period = '{10'd1023, 10'd1, 10'd12, 10'd1023};
        cfg_alpha  = '{17'd65535, 17'd1, 17'd21845, ALPHA_ONE};
        program_regs();
        send_bar(32'h7FFF_FFFF, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_FFFF, 1'b1);
        send_bar(32'hFFFF_FFFF, 1'b0);
        send_bar(32'h0123_4567, 1'b1);

        // Random phases, one with a long receiver hold-off
        for (int ph = 0; ph < 8; ph++)
            run_phase(90, ph == 2);

        settle();
        sb.finish_check();
        if (sb.errors == 0)
            $display("tb_quad_ema_sma_seeded: clean");
        else
            $display("tb_quad_ema_sma_seeded: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/qes_pkg.sv
rtl/qes_cfg.sv
rtl/qes_alu.sv
rtl/quad_ema_sma_seeded.sv
rtl/qes_chk.sv
tb/sv/tb_quad_ema_sma_seeded.sv
